[sv/correspondence_length_compatibility_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the correspondence length compatibility block
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef CORRESPONDENCE_LENGTH_COMPATIBILITY_TOP_ASSERT_SVH
`define CORRESPONDENCE_LENGTH_COMPATIBILITY_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define CLC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CLC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[sv/clc_pkg.sv]
// ----------------------------------------------------------------------------
// clc_pkg
// Shared widths, constants and types of the length compatibility pipeline.
// ----------------------------------------------------------------------------
package clc_pkg;

  localparam int COORD_W   = 32;
  localparam int SCORE_FB  = 16;
  localparam int SCORE_W   = SCORE_FB + 1;
  localparam int RES_W     = 31;
  localparam int DEN_W     = RES_W + 4;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int ROOT_W    = COORD_W;
  localparam int T_W       = 27;
  localparam int X_W       = 35;
  localparam int QF        = 30;
  localparam int TERMS     = 17;
  localparam int N_W       = 5;
  localparam int POW_STG   = 31;
  localparam logic [RES_W-1:0] RES_RESET = RES_W'(655);

  typedef struct packed {
    logic zero;
    logic one;
  } clc_flag_t;

  function automatic logic [QF:0] exp_neg_one();
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'd1 << QF;
    pos  = 64'd1 << QF;
    neg  = 64'd0;
    for (int k = 1; k <= TERMS; k++) begin
      term = ((term * (64'd1 << QF)) >> QF) / 64'(k);
      if (k % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return (pos >= neg) ? (QF+1)'(pos - neg) : '0;
  endfunction

  localparam logic [QF:0] EXP_NEG_ONE = exp_neg_one();

endpackage

[sv/clc_if.sv]
// ----------------------------------------------------------------------------
// clc_in_if / clc_out_if
// Valid/ready channels for correspondence pairs and compatibility scores.
// ----------------------------------------------------------------------------
interface clc_in_if;
  logic valid;
  logic ready;
  logic signed [clc_pkg::COORD_W-1:0] src_i_x, src_i_y, src_i_z;
  logic signed [clc_pkg::COORD_W-1:0] src_j_x, src_j_y, src_j_z;
  logic signed [clc_pkg::COORD_W-1:0] tgt_i_x, tgt_i_y, tgt_i_z;
  logic signed [clc_pkg::COORD_W-1:0] tgt_j_x, tgt_j_y, tgt_j_z;
  modport source (output valid, src_i_x, src_i_y, src_i_z, src_j_x, src_j_y, src_j_z,
                  tgt_i_x, tgt_i_y, tgt_i_z, tgt_j_x, tgt_j_y, tgt_j_z, input ready);
  modport sink (input valid, src_i_x, src_i_y, src_i_z, src_j_x, src_j_y, src_j_z,
                tgt_i_x, tgt_i_y, tgt_i_z, tgt_j_x, tgt_j_y, tgt_j_z, output ready);
endinterface

interface clc_out_if;
  logic valid;
  logic ready;
  logic [clc_pkg::SCORE_W-1:0] compat_score;
  modport source (output valid, compat_score, input ready);
  modport sink (input valid, compat_score, output ready);
endinterface

[sv/correspondence_length_compatibility_top.sv]
// ----------------------------------------------------------------------------
// correspondence_length_compatibility_top
// Length compatibility score of a pair of point correspondences.
// ----------------------------------------------------------------------------
// One transaction carries two source and two target points (signed Q16.16);
// the block returns exp(-(r/(10*resolution))^2) in Q1.16, where r is the
// difference of the source and target distances. A new transaction is taken
// every cycle while the result side accepts. Its main parts are the
// bit-serial square root (32 stages), the divider (27 stages), the Taylor
// series (two stages per term, 17 terms) and the exp(-1) powering (31 stages).
// The whole pipeline holds when a finished score is not taken. The resolution
// register should be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
`include "correspondence_length_compatibility_top_assert.svh"

module correspondence_length_compatibility_top (
  input  logic                        clk,
  input  logic                        rst_n,
  clc_in_if.sink                      in_if,
  clc_out_if.source                   out_if,
  input  logic                        cfg_we,
  input  logic [clc_pkg::RES_W-1:0]   cfg_wdata
);

  localparam int CW = clc_pkg::COORD_W;
  localparam int SW = clc_pkg::SQ_W;

  logic en;
  logic [clc_pkg::DEN_W-1:0] den_r;

  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      den_r <= (clc_pkg::DEN_W'(clc_pkg::RES_RESET) << 3) +
               (clc_pkg::DEN_W'(clc_pkg::RES_RESET) << 1);
    end else if (cfg_we) begin
      den_r <= (clc_pkg::DEN_W'(cfg_wdata) << 3) + (clc_pkg::DEN_W'(cfg_wdata) << 1);
    end
  end

  logic signed [CW-1:0] pa [6];
  logic signed [CW-1:0] pb [6];

  always_comb begin
    pa[0] = in_if.src_i_x; pa[1] = in_if.src_i_y; pa[2] = in_if.src_i_z;
    pb[0] = in_if.src_j_x; pb[1] = in_if.src_j_y; pb[2] = in_if.src_j_z;
    pa[3] = in_if.tgt_i_x; pa[4] = in_if.tgt_i_y; pa[5] = in_if.tgt_i_z;
    pb[3] = in_if.tgt_j_x; pb[4] = in_if.tgt_j_y; pb[5] = in_if.tgt_j_z;
  end

  logic          v1_r, v2_r, v3_r, v4_r;
  logic [CW-1:0] mag_r [6];
  logic [SW-1:0] sq_r  [6];
  logic [SW-1:0] ps_r  [2];
  logic [SW-1:0] c3_r  [2];
  logic [SW-1:0] sum_r [2];

  for (genvar g = 0; g < 6; g++) begin : g_axis
    logic signed [CW:0] d;
    assign d = {pa[g][CW-1], pa[g]} - {pb[g][CW-1], pb[g]};

    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[g] <= d[CW] ? CW'(-d) : d[CW-1:0];
        sq_r[g]  <= SW'(mag_r[g]) * SW'(mag_r[g]);
      end
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_sum
    logic [SW:0] s01;
    logic [SW:0] s012;
    assign s01  = {1'b0, sq_r[3*g]} + {1'b0, sq_r[3*g+1]};
    assign s012 = {1'b0, ps_r[g]} + {1'b0, c3_r[g]};

    always_ff @(posedge clk) begin
      if (en) begin
        ps_r[g]  <= s01[SW] ? '1 : s01[SW-1:0];
        c3_r[g]  <= sq_r[3*g+2];
        sum_r[g] <= s012[SW] ? '1 : s012[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_if.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  logic                        vs_src, vs_tgt;
  logic [clc_pkg::ROOT_W-1:0]  dist_src, dist_tgt;

  clc_sqrt u_sqrt_src (
    .clk, .rst_n, .en,
    .in_valid (v4_r), .rad (sum_r[0]),
    .out_valid (vs_src), .root (dist_src)
  );

  clc_sqrt u_sqrt_tgt (
    .clk, .rst_n, .en,
    .in_valid (v4_r), .rad (sum_r[1]),
    .out_valid (vs_tgt), .root (dist_tgt)
  );

  logic                        v5_r;
  logic [clc_pkg::ROOT_W-1:0]  r_r;
  clc_pkg::clc_flag_t          flg5_r;
  logic [clc_pkg::ROOT_W-1:0]  r_nxt;
  clc_pkg::clc_flag_t          flg5_nxt;

  always_comb begin
    r_nxt = (dist_src > dist_tgt) ? dist_src - dist_tgt : dist_tgt - dist_src;
    flg5_nxt.one  = (den_r == '0) && (r_nxt == '0);
    flg5_nxt.zero = !flg5_nxt.one &&
                    (clc_pkg::DEN_W'(r_nxt[clc_pkg::ROOT_W-1:3]) >= den_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= vs_src;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r    <= r_nxt;
      flg5_r <= flg5_nxt;
    end
  end

  logic                     vd;
  logic [clc_pkg::T_W-1:0]  t_d;
  clc_pkg::clc_flag_t       flg_d;

  clc_div u_div (
    .clk, .rst_n, .en,
    .in_valid (v5_r), .r (r_r), .in_flg (flg5_r), .den (den_r),
    .out_valid (vd), .t (t_d), .out_flg (flg_d)
  );

  logic                      v6_r;
  logic [clc_pkg::X_W-1:0]   x_r;
  clc_pkg::clc_flag_t        flg6_r;
  logic [2*clc_pkg::T_W-1:0] tsq;

  assign tsq = (2*clc_pkg::T_W)'(t_d) * (2*clc_pkg::T_W)'(t_d);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r         <= tsq[clc_pkg::X_W+17:18];
      flg6_r.one  <= flg_d.one;
      flg6_r.zero <= flg_d.zero || tsq[2*clc_pkg::T_W-1];
    end
  end

  clc_exp u_exp (
    .clk, .rst_n, .en,
    .in_valid (v6_r), .x (x_r), .in_flg (flg6_r),
    .out_valid (out_if.valid), .score (out_if.compat_score)
  );

  `CLC_ASSERT(a_score_max, clk, rst_n,
    out_if.valid |-> (out_if.compat_score <= (clc_pkg::SCORE_W'(1) << clc_pkg::SCORE_FB)),
    "score above one")
  `CLC_ASSERT(a_den_write, clk, rst_n,
    ($past(cfg_we) && $past(rst_n)) |-> (den_r == clc_pkg::DEN_W'($past(cfg_wdata)) * 10),
    "tolerance register does not follow the resolution write")
  `CLC_ASSERT(a_lanes_aligned, clk, rst_n,
    vs_src == vs_tgt,
    "square root lanes out of step")
  `CLC_ASSERT(a_flags_excl, clk, rst_n,
    v5_r |-> !(flg5_r.one && flg5_r.zero),
    "score forced to both one and zero")

endmodule

[sv/clc_sqrt.sv]
// ----------------------------------------------------------------------------
// clc_sqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module clc_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [clc_pkg::SQ_W-1:0]    rad,
  output logic                        out_valid,
  output logic [clc_pkg::ROOT_W-1:0]  root
);

  localparam int RW = clc_pkg::ROOT_W + 3;

  typedef struct packed {
    logic [RW-1:0]               rem;
    logic [clc_pkg::ROOT_W-1:0]  root;
    logic [clc_pkg::SQ_W-1:0]    rad;
  } sq_stage_t;

  sq_stage_t st_r [clc_pkg::ROOT_W+1];
  logic      v_r  [clc_pkg::ROOT_W+1];

  always_comb begin
    st_r[0] = '{rem: '0, root: '0, rad: rad};
    v_r[0]  = in_valid;
  end

  for (genvar g = 0; g < clc_pkg::ROOT_W; g++) begin : g_stage
    sq_stage_t st_nxt;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;

    always_comb begin
      rem_sh = {st_r[g].rem[RW-3:0], st_r[g].rad[clc_pkg::SQ_W-1 -: 2]};
      trial  = {1'b0, st_r[g].root, 2'b01};
      st_nxt.rad = {st_r[g].rad[clc_pkg::SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        st_nxt.rem  = rem_sh - trial;
        st_nxt.root = {st_r[g].root[clc_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        st_nxt.rem  = rem_sh;
        st_nxt.root = {st_r[g].root[clc_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else if (en) begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g+1] <= st_nxt;
      end
    end
  end

  assign out_valid = v_r[clc_pkg::ROOT_W];
  assign root      = st_r[clc_pkg::ROOT_W].root;

endmodule

[sv/clc_div.sv]
// ----------------------------------------------------------------------------
// clc_div
// Pipelined restoring divider forming the ratio of distance error to tolerance.
// ----------------------------------------------------------------------------
module clc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [clc_pkg::ROOT_W-1:0]  r,
  input  clc_pkg::clc_flag_t          in_flg,
  input  logic [clc_pkg::DEN_W-1:0]   den,
  output logic                        out_valid,
  output logic [clc_pkg::T_W-1:0]     t,
  output clc_pkg::clc_flag_t          out_flg
);

  typedef struct packed {
    logic [clc_pkg::DEN_W-1:0]  rem;
    logic [clc_pkg::T_W-1:0]    num;
    logic [clc_pkg::T_W-1:0]    quo;
    clc_pkg::clc_flag_t         flg;
  } dv_stage_t;

  dv_stage_t st_r [clc_pkg::T_W+1];
  logic      v_r  [clc_pkg::T_W+1];

  always_comb begin
    st_r[0].rem = clc_pkg::DEN_W'(r[clc_pkg::ROOT_W-1:3]);
    st_r[0].num = {r[2:0], 24'd0};
    st_r[0].quo = '0;
    st_r[0].flg = in_flg;
    v_r[0]      = in_valid;
  end

  for (genvar g = 0; g < clc_pkg::T_W; g++) begin : g_stage
    dv_stage_t st_nxt;
    logic [clc_pkg::DEN_W:0] rem_sh;

    always_comb begin
      rem_sh      = {st_r[g].rem, st_r[g].num[clc_pkg::T_W-1]};
      st_nxt.num  = {st_r[g].num[clc_pkg::T_W-2:0], 1'b0};
      st_nxt.flg  = st_r[g].flg;
      if (rem_sh >= {1'b0, den}) begin
        st_nxt.rem = clc_pkg::DEN_W'(rem_sh - {1'b0, den});
        st_nxt.quo = {st_r[g].quo[clc_pkg::T_W-2:0], 1'b1};
      end else begin
        st_nxt.rem = rem_sh[clc_pkg::DEN_W-1:0];
        st_nxt.quo = {st_r[g].quo[clc_pkg::T_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else if (en) begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g+1] <= st_nxt;
      end
    end
  end

  assign out_valid = v_r[clc_pkg::T_W];
  assign t         = st_r[clc_pkg::T_W].quo;
  assign out_flg   = st_r[clc_pkg::T_W].flg;

endmodule

[sv/clc_exp.sv]
// ----------------------------------------------------------------------------
// clc_exp
// Pipelined exp(-x) in Q30: Taylor series for the fraction, then one
// multiplication by exp(-1) per stage for the integer part, then rounding.
// ----------------------------------------------------------------------------
module clc_exp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [clc_pkg::X_W-1:0]      x,
  input  clc_pkg::clc_flag_t           in_flg,
  output logic                         out_valid,
  output logic [clc_pkg::SCORE_W-1:0]  score
);

  localparam int QF = clc_pkg::QF;

  typedef struct packed {
    logic [QF-1:0]             f;
    logic [clc_pkg::N_W-1:0]   n;
    clc_pkg::clc_flag_t        flg;
    logic [QF:0]               term;
    logic [QF+1:0]             pos;
    logic [QF+1:0]             neg;
  } ser_t;

  typedef struct packed {
    logic [clc_pkg::N_W-1:0]   n;
    clc_pkg::clc_flag_t        flg;
    logic [QF:0]               e;
  } pw_t;

  ser_t sa_r [clc_pkg::TERMS];
  logic va_r [clc_pkg::TERMS];
  ser_t sb_r [clc_pkg::TERMS+1];
  logic vb_r [clc_pkg::TERMS+1];
  pw_t  pw_r [clc_pkg::POW_STG+1];
  logic vp_r [clc_pkg::POW_STG+1];

  logic                        vo_r;
  logic [clc_pkg::SCORE_W-1:0] score_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r[0] <= 1'b0;
    end else if (en) begin
      vb_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0].f    <= x[QF-1:0];
      sb_r[0].n    <= x[clc_pkg::X_W-1:QF];
      sb_r[0].flg  <= in_flg;
      sb_r[0].term <= (QF+1)'(1) << QF;
      sb_r[0].pos  <= (QF+2)'(1) << QF;
      sb_r[0].neg  <= '0;
    end
  end

  for (genvar g = 0; g < clc_pkg::TERMS; g++) begin : g_term
    localparam int K = g + 1;
    localparam int L = $clog2(K);
    localparam logic [32:0] RECIP = 33'(((64'd1 << (31 + L)) + 64'(K) - 64'd1) / 64'(K));
    logic [2*QF:0] prod;
    logic [63:0]   qprod;
    logic [QF:0]   quo;
    ser_t          sa_nxt;
    ser_t          sb_nxt;

    always_comb begin
      prod        = (2*QF+1)'(sb_r[g].term) * (2*QF+1)'(sb_r[g].f);
      sa_nxt      = sb_r[g];
      sa_nxt.term = prod[2*QF:QF];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[g] <= 1'b0;
      end else if (en) begin
        va_r[g] <= vb_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sa_r[g] <= sa_nxt;
      end
    end

    always_comb begin
      qprod  = 64'(sa_r[g].term) * 64'(RECIP);
      quo    = (QF+1)'(qprod >> (31 + L));
      sb_nxt = sa_r[g];
      sb_nxt.term = quo;
      if (K % 2 == 1) begin
        sb_nxt.neg = sa_r[g].neg + (QF+2)'(quo);
      end else begin
        sb_nxt.pos = sa_r[g].pos + (QF+2)'(quo);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vb_r[g+1] <= 1'b0;
      end else if (en) begin
        vb_r[g+1] <= va_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[g+1] <= sb_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r[0] <= 1'b0;
    end else if (en) begin
      vp_r[0] <= vb_r[clc_pkg::TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw_r[0].n   <= sb_r[clc_pkg::TERMS].n;
      pw_r[0].flg <= sb_r[clc_pkg::TERMS].flg;
      pw_r[0].e   <= (sb_r[clc_pkg::TERMS].pos >= sb_r[clc_pkg::TERMS].neg) ?
                     (QF+1)'(sb_r[clc_pkg::TERMS].pos - sb_r[clc_pkg::TERMS].neg) : '0;
    end
  end

  for (genvar g = 0; g < clc_pkg::POW_STG; g++) begin : g_pow
    logic [2*QF+1:0] eprod;
    pw_t             pw_nxt;

    always_comb begin
      eprod  = (2*QF+2)'(pw_r[g].e) * (2*QF+2)'(clc_pkg::EXP_NEG_ONE);
      pw_nxt = pw_r[g];
      if (clc_pkg::N_W'(g) < pw_r[g].n) begin
        pw_nxt.e = (QF+1)'(eprod >> QF);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vp_r[g+1] <= 1'b0;
      end else if (en) begin
        vp_r[g+1] <= vp_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pw_r[g+1] <= pw_nxt;
      end
    end
  end

  localparam int RSH = QF - clc_pkg::SCORE_FB;
  localparam logic [clc_pkg::SCORE_W-1:0] SCORE_ONE = clc_pkg::SCORE_W'(1) << clc_pkg::SCORE_FB;

  logic [QF+1:0] rnd_sum;
  logic [QF+1:0] rnd_q;
  logic [clc_pkg::SCORE_W-1:0] score_nxt;

  always_comb begin
    rnd_sum = (QF+2)'(pw_r[clc_pkg::POW_STG].e) + ((QF+2)'(1) << (RSH - 1));
    rnd_q   = rnd_sum >> RSH;
    priority if (pw_r[clc_pkg::POW_STG].flg.one) begin
      score_nxt = SCORE_ONE;
    end else if (pw_r[clc_pkg::POW_STG].flg.zero) begin
      score_nxt = '0;
    end else if (rnd_q > (QF+2)'(SCORE_ONE)) begin
      score_nxt = SCORE_ONE;
    end else begin
      score_nxt = rnd_q[clc_pkg::SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= vp_r[clc_pkg::POW_STG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      score_r <= score_nxt;
    end
  end

  assign out_valid = vo_r;
  assign score     = score_r;

endmodule

[dv/correspondence_length_compatibility_top_test.sv]
// ----------------------------------------------------------------------------
// Length compatibility block testbench
// Sends pairs of correspondences through the input channel, predicts each
// score in fixed point from the coordinates and the resolution in force, and
// compares every returned score in order. The run covers several resolutions,
// random idling on both sides and a long hold-off on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module correspondence_length_compatibility_top_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 150;

  typedef logic signed [clc_pkg::COORD_W-1:0] coord_t;
  typedef logic [clc_pkg::SCORE_W-1:0] score_t;

  typedef struct packed {
    coord_t src_i_x, src_i_y, src_i_z;
    coord_t src_j_x, src_j_y, src_j_z;
    coord_t tgt_i_x, tgt_i_y, tgt_i_z;
    coord_t tgt_j_x, tgt_j_y, tgt_j_z;
  } pair_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [clc_pkg::RES_W-1:0] cfg_wdata;

  clc_in_if in_ch();
  clc_out_if out_ch();

  correspondence_length_compatibility_top i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  logic [clc_pkg::RES_W-1:0] resolution;
  score_t score_q[$];
  int errors;
  int cycles;
  int hold_left;
  bit steady;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] sq_diff(coord_t a, coord_t b);
    logic signed [63:0] d;
    d = 64'(a) - 64'(b);
    if (d < 0) d = -d;
    if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
    return d * d;
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s < a) ? '1 : s;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] span(coord_t ax, coord_t ay, coord_t az,
                                       coord_t bx, coord_t by, coord_t bz);
    logic [63:0] s;
    s = sq_diff(ax, bx);
    s = sat_sum(s, sq_diff(ay, by));
    s = sat_sum(s, sq_diff(az, bz));
    return floor_sqrt(s);
  endfunction

  function automatic logic [63:0] decay_frac(logic [63:0] f);
    logic [63:0] term, pos, neg;
    term = 64'd1 << clc_pkg::QF;
    pos = term;
    neg = 0;
    for (int k = 1; k <= clc_pkg::TERMS; k++) begin
      term = ((term * f) >> clc_pkg::QF) / 64'(k);
      if (k % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return (pos >= neg) ? pos - neg : 0;
  endfunction

  function automatic score_t compat_score_of(pair_t p, logic [clc_pkg::RES_W-1:0] res);
    logic [63:0] ds, dt, r, den, t, x, e, e1, s;
    logic [63:0] one;
    one = 64'd1 << clc_pkg::SCORE_FB;
    ds = span(p.src_i_x, p.src_i_y, p.src_i_z, p.src_j_x, p.src_j_y, p.src_j_z);
    dt = span(p.tgt_i_x, p.tgt_i_y, p.tgt_i_z, p.tgt_j_x, p.tgt_j_y, p.tgt_j_z);
    r = (ds > dt) ? ds - dt : dt - ds;
    den = 64'd10 * 64'(res);
    if (den == 0) begin
      s = (r == 0) ? one : 0;
    end else begin
      t = (r << 24) / den;
      if (t >= (64'd8 << 24)) begin
        s = 0;
      end else begin
        x = (t * t) >> 18;
        if (x >= (64'd32 << clc_pkg::QF)) begin
          s = 0;
        end else begin
          e = decay_frac(x & ((64'd1 << clc_pkg::QF) - 1));
          e1 = decay_frac(64'd1 << clc_pkg::QF);
          for (int i = 0; i < int'(x >> clc_pkg::QF); i++) e = (e * e1) >> clc_pkg::QF;
          s = (e + (64'd1 << (clc_pkg::QF - 1 - clc_pkg::SCORE_FB))) >>
              (clc_pkg::QF - clc_pkg::SCORE_FB);
          if (s > one) s = one;
        end
      end
    end
    return clc_pkg::SCORE_W'(s);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      score_q.push_back(compat_score_of({in_ch.src_i_x, in_ch.src_i_y, in_ch.src_i_z,
                                         in_ch.src_j_x, in_ch.src_j_y, in_ch.src_j_z,
                                         in_ch.tgt_i_x, in_ch.tgt_i_y, in_ch.tgt_i_z,
                                         in_ch.tgt_j_x, in_ch.tgt_j_y, in_ch.tgt_j_z},
                                        resolution));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (score_q.size() == 0) begin
        $display("%0t: unexpected score %0d", $time, out_ch.compat_score);
        errors++;
      end else begin
        if (out_ch.compat_score !== score_q[0]) begin
          $display("%0t: compat_score expected %0d actual %0d", $time, score_q[0],
                   out_ch.compat_score);
          errors++;
        end
        void'(score_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= 25);
    end
  end

  task automatic send_pair(pair_t p);
    if (!steady && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.src_i_x, in_ch.src_i_y, in_ch.src_i_z,
     in_ch.src_j_x, in_ch.src_j_y, in_ch.src_j_z,
     in_ch.tgt_i_x, in_ch.tgt_i_y, in_ch.tgt_i_z,
     in_ch.tgt_j_x, in_ch.tgt_j_y, in_ch.tgt_j_z} <= p;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (score_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_resolution(logic [clc_pkg::RES_W-1:0] res);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= res;
    @(posedge clk);
    cfg_we <= 1'b0;
    resolution = res;
  endtask

  function automatic coord_t scaled_coord(int lo, int hi);
    return coord_t'($signed($urandom) >>> $urandom_range(lo, hi));
  endfunction

  // Most pairs keep the target length close to the source length so the
  // score lands in the interesting range; the rest are fully random.
  function automatic pair_t random_pair();
    pair_t p;
    coord_t d[3];
    coord_t tmp;
    logic [63:0] lim;
    int k;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(9) < 2) return p;
    p.src_i_x = scaled_coord(2, 16);
    p.src_i_y = scaled_coord(2, 16);
    p.src_i_z = scaled_coord(2, 16);
    p.tgt_i_x = scaled_coord(2, 16);
    p.tgt_i_y = scaled_coord(2, 16);
    p.tgt_i_z = scaled_coord(2, 16);
    for (int i = 0; i < 3; i++) d[i] = scaled_coord(4, 22);
    p.src_j_x = p.src_i_x + d[0];
    p.src_j_y = p.src_i_y + d[1];
    p.src_j_z = p.src_i_z + d[2];
    k = $urandom_range(2);
    tmp = d[0];
    d[0] = d[k];
    d[k] = tmp;
    for (int i = 0; i < 3; i++) if ($urandom_range(1)) d[i] = -d[i];
    lim = 64'(resolution) * 24;
    if (lim > 64'h10_0000) lim = 64'h10_0000;
    if ($urandom_range(3) != 0) d[$urandom_range(2)] += coord_t'($urandom_range(0, int'(lim)));
    p.tgt_j_x = p.tgt_i_x + d[0];
    p.tgt_j_y = p.tgt_i_y + d[1];
    p.tgt_j_z = p.tgt_i_z + d[2];
    return p;
  endfunction

  task automatic test_directed();
    coord_t mn, mx;
    mn = coord_t'(32'h8000_0000);
    mx = coord_t'(32'h7FFF_FFFF);
    send_pair('0);
    send_pair({mn, mn, mn, mx, mx, mx, mn, mn, mn, mx, mx, mx});
    send_pair({mn, mn, mn, mx, mx, mx, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    send_pair({mx, mx, mx, mn, mn, mn, mx, 32'sd0, 32'sd0, mn, 32'sd0, 32'sd0});
    send_pair({32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0,
               32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd65536 + 32'sd5, 32'sd5});
    for (int i = 1; i <= 10; i++) begin
      send_pair({32'sd0, 32'sd0, 32'sd0, 32'sd131072, 32'sd0, 32'sd0,
                 32'sd0, 32'sd0, 32'sd0, 32'sd131072 + 32'(i * i * 3000), 32'sd0, 32'sd0});
    end
    send_pair({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
               32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd52400});
    send_pair({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
               32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd52300});
    send_pair({mx, mn, mx, mn, mx, mn, mn, mx, mn, mx, mn, mx});
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_pair(random_pair());
  endtask

  task automatic test_backpressure(int count);
    steady = 1'b1;
    hold_left = 400;
    for (int i = 0; i < count; i++) send_pair(random_pair());
    steady = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    {in_ch.src_i_x, in_ch.src_i_y, in_ch.src_i_z,
     in_ch.src_j_x, in_ch.src_j_y, in_ch.src_j_z,
     in_ch.tgt_i_x, in_ch.tgt_i_y, in_ch.tgt_i_z,
     in_ch.tgt_j_x, in_ch.tgt_j_y, in_ch.tgt_j_z} = '0;
    out_ch.ready = 1'b0;
    resolution = clc_pkg::RES_RESET;
    errors = 0;
    cycles = 0;
    hold_left = 0;
    steady = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(250);
    set_resolution(clc_pkg::RES_W'(1));
    test_directed();
    test_random(120);
    set_resolution('1);
    test_random(120);
    set_resolution(clc_pkg::RES_W'($urandom_range(1, 100000)));
    steady = 1'b1;
    test_random(200);
    steady = 1'b0;
    set_resolution(clc_pkg::RES_W'($urandom_range(30000, 70000)));
    test_random(150);
    test_backpressure(250);
    set_resolution(clc_pkg::RES_RESET);
    test_random(50);
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
